// File: src/cst_pkg.sv
// Shared constants, codes and types of the cursor sequence table.
package cst_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int CMD_W = 4;
    localparam int VAL_W = 64;
    localparam int POS_W = 6;
    localparam int ST_W  = 3;
    localparam int CNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_START        = 4'd0;
    localparam logic [CMD_W-1:0] CMD_END          = 4'd1;
    localparam logic [CMD_W-1:0] CMD_ADVANCE      = 4'd2;
    localparam logic [CMD_W-1:0] CMD_RETREAT      = 4'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT       = 4'd4;
    localparam logic [CMD_W-1:0] CMD_ATTACH       = 4'd5;
    localparam logic [CMD_W-1:0] CMD_REMOVE_CUR   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_INSERT_FRONT = 4'd7;
    localparam logic [CMD_W-1:0] CMD_ATTACH_BACK  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_REMOVE_FRONT = 4'd9;
    localparam logic [CMD_W-1:0] CMD_READ_AT      = 4'd10;

    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd1;
    localparam logic [ST_W-1:0] ST_NOCUR  = 3'd2;
    localparam logic [ST_W-1:0] ST_ATEND  = 3'd3;
    localparam logic [ST_W-1:0] ST_ATBEG  = 3'd4;
    localparam logic [ST_W-1:0] ST_BADPOS = 3'd5;

    // Memory work a command needs: nothing, open a gap, close a gap
    typedef enum logic [1:0] {
        OP_NONE,
        OP_OPEN,
        OP_CLOSE
    } cst_op_t;

    typedef struct packed {
        cst_op_t         op;
        logic [ST_W-1:0] status;
        logic            do_read;
    } cst_plan_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] item_count;
        logic [CNT_W-1:0] cursor;
        logic             has_current;
        logic [VAL_W-1:0] current_value;
        logic [VAL_W-1:0] read_value;
    } cst_result_t;

endpackage

// File: src/cst_if.sv
// Command and result channel interfaces of the cursor sequence table.
interface cst_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [cst_pkg::CMD_W-1:0] command;
    logic [cst_pkg::VAL_W-1:0] entry_value;
    logic [cst_pkg::POS_W-1:0] position;

    modport source (output valid, output command, output entry_value, output position,
                    input ready);
    modport sink (input valid, input command, input entry_value, input position,
                  output ready);
endinterface

interface cst_res_if;
    logic                      valid;
    logic                      ready;
    logic [cst_pkg::ST_W-1:0]  status;
    logic [cst_pkg::CNT_W-1:0] item_count;
    logic [cst_pkg::CNT_W-1:0] cursor;
    logic                      has_current;
    logic [cst_pkg::VAL_W-1:0] current_value;
    logic [cst_pkg::VAL_W-1:0] read_value;

    modport source (output valid, output status, output item_count, output cursor,
                    output has_current, output current_value, output read_value,
                    input ready);
    modport sink (input valid, input status, input item_count, input cursor,
                  input has_current, input current_value, input read_value,
                  output ready);
endinterface

// File: src/cursor_sequence_table_unit.sv
// Command flow: take the command beat, shift the entries to open or close a gap,
// write the word when one is stored, fetch the read and current entries, then pass the result on.
// A new command is taken only once the engine has handed its last result on and is idle.
// The entry memory has one read and one write port; one entry moves per cycle in a shift.
// Reset: count and cursor clear to zero at once; the entry memory is not cleared,
// as no result shows an entry that was never written.
module cursor_sequence_table_unit #(
    parameter int DEPTH = cst_pkg::DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    cst_cmd_if.sink    cmd,
    cst_res_if.source  res
);

    localparam int CW = $clog2(DEPTH+1);

    cst_pkg::cst_plan_t   plan;
    logic [CW-1:0]        at;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        cursor_next;
    logic [CW-1:0]        count;
    logic [CW-1:0]        cursor;
    logic                 idle;
    logic                 eng_valid;
    logic                 eng_ready;
    cst_pkg::cst_result_t eng_res;

    logic                 out_valid_reg;
    cst_pkg::cst_result_t out_reg;

    // Take a command beat only between commands
    assign cmd.ready = idle;

    cst_decode #(
        .DEPTH (DEPTH)
    ) u_decode (
        .command     (cmd.command),
        .position    (cmd.position),
        .count       (count),
        .cursor      (cursor),
        .plan        (plan),
        .at          (at),
        .count_next  (count_next),
        .cursor_next (cursor_next)
    );

    cst_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmd.valid & idle),
        .plan        (plan),
        .at          (at),
        .count_next  (count_next),
        .cursor_next (cursor_next),
        .entry_value (cmd.entry_value),
        .position    (cmd.position),
        .count       (count),
        .cursor      (cursor),
        .idle        (idle),
        .res_valid   (eng_valid),
        .res_ready   (eng_ready),
        .res         (eng_res)
    );

    // Output register: hold a finished result until the sink takes the beat,
    // so the engine can go back to idle and take the next command meanwhile.
    assign eng_ready = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (eng_valid && eng_ready)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (eng_valid && eng_ready)
            out_reg <= eng_res;
    end

    assign res.valid         = out_valid_reg;
    assign res.status        = out_reg.status;
    assign res.item_count    = out_reg.item_count;
    assign res.cursor        = out_reg.cursor;
    assign res.has_current   = out_reg.has_current;
    assign res.current_value = out_reg.current_value;
    assign res.read_value    = out_reg.read_value;

endmodule

// File: src/cst_decode.sv
// Command decode: checks, new count and cursor, and the memory work to do.
module cst_decode #(
    parameter int DEPTH = cst_pkg::DEPTH_DEFAULT
) (
    input  logic [cst_pkg::CMD_W-1:0]    command,
    input  logic [cst_pkg::POS_W-1:0]    position,
    input  logic [$clog2(DEPTH+1)-1:0]   count,
    input  logic [$clog2(DEPTH+1)-1:0]   cursor,
    output cst_pkg::cst_plan_t           plan,
    output logic [$clog2(DEPTH+1)-1:0]   at,
    output logic [$clog2(DEPTH+1)-1:0]   count_next,
    output logic [$clog2(DEPTH+1)-1:0]   cursor_next
);

    localparam int CW   = $clog2(DEPTH+1);
    localparam int CMPW = (CW > cst_pkg::POS_W) ? CW : cst_pkg::POS_W;

    logic          cur;
    logic          full;
    logic          last;
    logic [CW-1:0] count_inc;
    logic [CW-1:0] count_dec;

    assign cur       = cursor < count;
    assign full      = count == CW'(DEPTH);
    assign last      = cursor == CW'(DEPTH - 1);
    assign count_inc = count + 1'b1;
    assign count_dec = count - 1'b1;

    always_comb
    begin
        plan.op      = cst_pkg::OP_NONE;
        plan.status  = cst_pkg::ST_OK;
        plan.do_read = 1'b0;
        at           = cursor;
        count_next   = count;
        cursor_next  = cursor;
        case (command)
            cst_pkg::CMD_START:
            begin
                cursor_next = '0;
            end
            cst_pkg::CMD_END:
            begin
                cursor_next = (count == '0) ? '0 : count_dec;
            end
            cst_pkg::CMD_ADVANCE:
            begin
                if (!cur)
                    plan.status = cst_pkg::ST_NOCUR;
                else if (last)
                    plan.status = cst_pkg::ST_ATEND;
                else
                    cursor_next = cursor + 1'b1;
            end
            cst_pkg::CMD_RETREAT:
            begin
                if (cursor == '0)
                    plan.status = cst_pkg::ST_ATBEG;
                else
                    cursor_next = cursor - 1'b1;
            end
            cst_pkg::CMD_INSERT:
            begin
                if (full)
                    plan.status = cst_pkg::ST_FULL;
                else
                begin
                    plan.op    = cst_pkg::OP_OPEN;
                    count_next = count_inc;
                end
            end
            cst_pkg::CMD_ATTACH:
            begin
                if (full)
                    plan.status = cst_pkg::ST_FULL;
                else
                begin
                    plan.op     = cst_pkg::OP_OPEN;
                    count_next  = count_inc;
                    at          = cur ? CW'(cursor + 1'b1) : count;
                    cursor_next = at;
                end
            end
            cst_pkg::CMD_REMOVE_CUR:
            begin
                if (!cur)
                    plan.status = cst_pkg::ST_NOCUR;
                else
                begin
                    plan.op    = cst_pkg::OP_CLOSE;
                    count_next = count_dec;
                end
            end
            cst_pkg::CMD_INSERT_FRONT:
            begin
                if (full)
                    plan.status = cst_pkg::ST_FULL;
                else
                begin
                    plan.op     = cst_pkg::OP_OPEN;
                    count_next  = count_inc;
                    at          = '0;
                    cursor_next = '0;
                end
            end
            cst_pkg::CMD_ATTACH_BACK:
            begin
                if (full)
                    plan.status = cst_pkg::ST_FULL;
                else
                begin
                    plan.op     = cst_pkg::OP_OPEN;
                    count_next  = count_inc;
                    at          = count;
                    cursor_next = count;
                end
            end
            cst_pkg::CMD_REMOVE_FRONT:
            begin
                if (count == '0)
                    plan.status = cst_pkg::ST_NOCUR;
                else
                begin
                    plan.op     = cst_pkg::OP_CLOSE;
                    count_next  = count_dec;
                    at          = '0;
                    cursor_next = '0;
                end
            end
            cst_pkg::CMD_READ_AT:
            begin
                if (CMPW'(position) >= CMPW'(count))
                    plan.status = cst_pkg::ST_BADPOS;
                else
                    plan.do_read = 1'b1;
            end
            default:
            begin
                plan.op = cst_pkg::OP_NONE;
            end
        endcase
    end

endmodule

// File: src/cst_engine.sv
// Entry memory with the shift sequencer and the result fetch.
module cst_engine #(
    parameter int DEPTH = cst_pkg::DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  cst_pkg::cst_plan_t           plan,
    input  logic [$clog2(DEPTH+1)-1:0]   at,
    input  logic [$clog2(DEPTH+1)-1:0]   count_next,
    input  logic [$clog2(DEPTH+1)-1:0]   cursor_next,
    input  logic [cst_pkg::VAL_W-1:0]    entry_value,
    input  logic [cst_pkg::POS_W-1:0]    position,
    output logic [$clog2(DEPTH+1)-1:0]   count,
    output logic [$clog2(DEPTH+1)-1:0]   cursor,
    output logic                         idle,
    output logic                         res_valid,
    input  logic                         res_ready,
    output cst_pkg::cst_result_t         res
);

    localparam int CW    = $clog2(DEPTH+1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW    = cst_pkg::VAL_W;
    localparam int CNT_W = cst_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_FETCH_POS,
        S_FETCH_CUR,
        S_FETCH_WAIT,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     cursor_reg;
    cst_pkg::cst_op_t  op_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     left_reg;
    logic              pend_reg;
    logic [AW-1:0]     pend_addr_reg;

    logic [cst_pkg::ST_W-1:0] status_reg;
    logic                     do_read_reg;
    logic [CW-1:0]            at_reg;
    logic [VW-1:0]            val_reg;
    logic [AW-1:0]            pos_reg;
    logic [VW-1:0]            rd_data_reg;
    cst_pkg::cst_result_t     res_reg;

    logic [VW-1:0] mem [DEPTH];
    logic [VW-1:0] mem_q;
    logic          we;
    logic [AW-1:0] waddr;
    logic [VW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic          is_open;

    assign count     = count_reg;
    assign cursor    = cursor_reg;
    assign idle      = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res       = res_reg;
    assign is_open   = op_reg == cst_pkg::OP_OPEN;

    // One write and one registered read a cycle; a pending shift write lands
    // in the cycle after its read is issued, as the read data arrives.
    always_comb
    begin
        we    = pend_reg;
        waddr = pend_addr_reg;
        wdata = mem_q;
        raddr = '0;
        case (state_reg)
            S_SHIFT:     raddr = idx_reg[AW-1:0];
            S_PUT:
            begin
                we    = 1'b1;
                waddr = at_reg[AW-1:0];
                wdata = val_reg;
            end
            S_FETCH_POS: raddr = pos_reg;
            S_FETCH_CUR: raddr = cursor_reg[AW-1:0];
            default:     raddr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        mem_q <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            op_reg        <= cst_pkg::OP_NONE;
            idx_reg       <= '0;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        count_reg  <= count_next;
                        cursor_reg <= cursor_next;
                        op_reg     <= plan.op;
                        pend_reg   <= 1'b0;
                        case (plan.op)
                            cst_pkg::OP_OPEN:
                            begin
                                left_reg <= count_reg - at;
                                idx_reg  <= count_reg - 1'b1;
                            end
                            cst_pkg::OP_CLOSE:
                            begin
                                left_reg <= count_reg - at - 1'b1;
                                idx_reg  <= at + 1'b1;
                            end
                            default:
                            begin
                                left_reg <= '0;
                                idx_reg  <= '0;
                            end
                        endcase
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    if (left_reg != '0)
                    begin
                        // open moves entries up from the top, close moves them down
                        left_reg <= left_reg - 1'b1;
                        pend_reg <= 1'b1;
                        if (is_open)
                        begin
                            idx_reg       <= idx_reg - 1'b1;
                            pend_addr_reg <= AW'(idx_reg + 1'b1);
                        end
                        else
                        begin
                            idx_reg       <= idx_reg + 1'b1;
                            pend_addr_reg <= AW'(idx_reg - 1'b1);
                        end
                    end
                    else
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= is_open ? S_PUT : S_FETCH_POS;
                    end
                end
                S_PUT:        state_reg <= S_FETCH_POS;
                S_FETCH_POS:  state_reg <= S_FETCH_CUR;
                S_FETCH_CUR:  state_reg <= S_FETCH_WAIT;
                S_FETCH_WAIT: state_reg <= S_DONE;
                S_DONE:
                begin
                    if (res_ready)
                        state_reg <= S_IDLE;
                end
                default:      state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            status_reg  <= plan.status;
            do_read_reg <= plan.do_read;
            at_reg      <= at;
            val_reg     <= entry_value;
            pos_reg     <= AW'(position);
        end
        if (state_reg == S_FETCH_CUR)
            rd_data_reg <= mem_q;
        if (state_reg == S_FETCH_WAIT)
        begin
            res_reg.status        <= status_reg;
            res_reg.item_count    <= CNT_W'(count_reg);
            res_reg.cursor        <= CNT_W'(cursor_reg);
            res_reg.has_current   <= cursor_reg < count_reg;
            res_reg.current_value <= (cursor_reg < count_reg) ? mem_q : '0;
            res_reg.read_value    <= do_read_reg ? rd_data_reg : '0;
        end
    end

`ifndef SYNTH
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("cursor beyond count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count beyond depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + 1'b1) ||
             (count_reg == $past(count_reg) - 1'b1)))
        else $error("count moved by more than one");

    a_count_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(state_reg == S_IDLE && start))
        else $error("count changed outside command start");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !start)
        else $error("command taken while busy");
`endif

endmodule
